// File: hdl/mvp_pkg.sv
package mvp_pkg;

	// Vector store depth; sets the column counter and address widths.
	localparam int unsigned MAX_COLUMNS = 1024;
	localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
	localparam int unsigned LEN_W       = (COL_W + 1 > 11) ? COL_W + 1 : 11;

	localparam int unsigned VAL_W  = 16;
	localparam int unsigned PROD_W = 32;
	localparam int unsigned SUM_W  = 40;
	localparam int unsigned ROW_W  = 16;
	localparam int unsigned RLEN_W = 11;

	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// Register byte addresses
	localparam logic [APB_AW-1:0] ADDR_ROW_LENGTH = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_ROW_COUNT  = 3'd4;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_MATRIX = 1'b1;

	typedef struct packed {
		logic                    valid;
		logic                    last;
		logic signed [VAL_W-1:0] value;
	} fetch_t;

endpackage

// File: hdl/mvp_fetch.sv
module mvp_fetch (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 accept,
	input  logic                                 req_type,
	input  logic signed [mvp_pkg::VAL_W-1:0]     element_value,
	input  logic        [mvp_pkg::RLEN_W-1:0]    row_length,
	output mvp_pkg::fetch_t                      fetch_s1,
	output logic signed [mvp_pkg::VAL_W-1:0]     vec_data_s1
);
	import mvp_pkg::*;

	logic signed [VAL_W-1:0] mem [MAX_COLUMNS];

	logic [COL_W-1:0] load_pos_q;
	logic [COL_W-1:0] col_pos_q;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] rlen_ext;
	logic [COL_W-1:0] wpos;
	logic [COL_W-1:0] col;
	logic [LEN_W-1:0] wpos_inc;
	logic [LEN_W-1:0] col_inc;
	logic [LEN_W-1:0] colraw_inc;
	logic             is_load;
	logic             is_mat;
	logic             last;

	assign is_load = accept && (req_type == REQ_LOAD);
	assign is_mat  = accept && (req_type == REQ_MATRIX);

	// zero acts as one, anything past the store depth as the depth
	always_comb begin
		rlen_ext = LEN_W'(row_length);
		if (rlen_ext == '0) begin
			len = LEN_W'(1);
		end else if (rlen_ext > LEN_W'(MAX_COLUMNS)) begin
			len = LEN_W'(MAX_COLUMNS);
		end else begin
			len = rlen_ext;
		end
		wpos       = (LEN_W'(load_pos_q) < len) ? load_pos_q : '0;
		col        = (LEN_W'(col_pos_q) < len) ? col_pos_q : '0;
		wpos_inc   = LEN_W'(wpos) + LEN_W'(1);
		col_inc    = LEN_W'(col) + LEN_W'(1);
		colraw_inc = LEN_W'(col_pos_q) + LEN_W'(1);
		last       = (colraw_inc >= len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_pos_q  <= '0;
		end else begin
			if (is_load) begin
				load_pos_q <= (wpos_inc >= len) ? '0 : wpos_inc[COL_W-1:0];
			end
			if (is_mat) begin
				col_pos_q <= last ? '0 : col_inc[COL_W-1:0];
			end
		end
	end

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (is_load) begin
			mem[wpos] <= element_value;
		end
		if (is_mat) begin
			vec_data_s1 <= mem[col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s1 <= '0;
		end else begin
			if (adv) begin
				fetch_s1.valid <= is_mat;
			end
			if (is_mat) begin
				fetch_s1.last  <= last;
				fetch_s1.value <= element_value;
			end
		end
	end

endmodule

// File: hdl/mvp_mac.sv
module mvp_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  mvp_pkg::fetch_t                      fetch_s1,
	input  logic signed [mvp_pkg::VAL_W-1:0]     vec_data_s1,
	input  logic        [mvp_pkg::ROW_W-1:0]     row_count,
	input  logic                                 result_stall,
	output logic                                 result_valid,
	output logic signed [mvp_pkg::SUM_W-1:0]     row_result,
	output logic        [mvp_pkg::ROW_W-1:0]     row_index,
	output logic                                 saturated
);
	import mvp_pkg::*;

	logic                     valid_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [SUM_W-1:0]  sum_q;
	logic                     clamp_q;
	logic        [ROW_W-1:0]  row_q;
	logic                     result_valid_q;

	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;
	logic                     ovf;
	logic        [ROW_W:0]    row_inc;
	logic        [ROW_W-1:0]  row_next;
	logic                     fire;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= fetch_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fetch_s1.valid) begin
			prod_s2 <= PROD_W'(fetch_s1.value * vec_data_s1);
			last_s2 <= fetch_s1.last;
		end
	end

	// accumulate with clamping at the 40-bit bounds
	always_comb begin
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(prod_s2);
		ovf      = sum_wide[SUM_W] != sum_wide[SUM_W-1];
		if (!ovf) begin
			sum_sat = sum_wide[SUM_W-1:0];
		end else if (sum_wide[SUM_W]) begin
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end
		row_inc  = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
		row_next = (row_inc >= (ROW_W+1)'(row_count)) ? '0 : row_inc[ROW_W-1:0];
		fire     = adv && valid_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			clamp_q        <= 1'b0;
			row_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (last_s2) begin
					sum_q   <= '0;
					clamp_q <= 1'b0;
					row_q   <= row_next;
				end else begin
					sum_q   <= sum_sat;
					clamp_q <= clamp_q || ovf;
				end
			end
			if (fire && last_s2) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s2) begin
			row_result <= sum_sat;
			row_index  <= row_q;
			saturated  <= clamp_q || ovf;
		end
	end

	assign result_valid = result_valid_q;

endmodule

// File: hdl/matrix_vector_product.sv
// Fixed-point matrix-vector product. Load items (req_type 0) fill the vector
// store in order, wrapping after row_length entries; matrix items (req_type 1)
// then stream in row-major order, each multiplied by the vector element of its
// column and added to a Q24.16 row sum clamped at the 40-bit bounds. After the
// last column of a row one result item carries the sum, the row index
// (wrapping after row_count rows) and a flag that is set if any add in the
// row was clamped. One item is taken every clock cycle while item_stall is
// low; a row's result follows its last matrix item through the store read,
// multiply and accumulate registers. Input stall rises only while the consumer
// stalls a result held in the output register, which freezes the whole pipeline.
// Vector store reads and writes are done in item order at acceptance on a
// single one-write/one-read memory, so loads mid-row behave as in sequence.
// Registers: row_length at byte 0, row_count at byte 4; write them only idle.
module matrix_vector_product (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 req_type,
	input  logic signed [mvp_pkg::VAL_W-1:0]     element_value,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [mvp_pkg::SUM_W-1:0]     row_result,
	output logic        [mvp_pkg::ROW_W-1:0]     row_index,
	output logic                                 saturated,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic        [mvp_pkg::APB_AW-1:0]    paddr,
	input  logic        [mvp_pkg::APB_DW-1:0]    pwdata,
	output logic        [mvp_pkg::APB_DW-1:0]    prdata,
	output logic                                 pready
);
	import mvp_pkg::*;

	logic [RLEN_W-1:0] row_length_q;
	logic [ROW_W-1:0]  row_count_q;
	logic              adv;
	logic              accept;
	logic              wr_en;
	fetch_t            fetch_s1;
	logic signed [VAL_W-1:0] vec_data_s1;

	// pipeline moves unless a finished result is held by the consumer
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;

	// config port, never inserts wait states
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= RLEN_W'(1024);
			row_count_q  <= ROW_W'(1024);
		end else if (wr_en) begin
			case (paddr)
				ADDR_ROW_LENGTH: row_length_q <= pwdata[RLEN_W-1:0];
				ADDR_ROW_COUNT:  row_count_q  <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_ROW_LENGTH: prdata = APB_DW'(row_length_q);
			ADDR_ROW_COUNT:  prdata = APB_DW'(row_count_q);
			default:         prdata = '0;
		endcase
	end

	mvp_fetch u_fetch (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.accept        (accept),
		.req_type      (req_type),
		.element_value (element_value),
		.row_length    (row_length_q),
		.fetch_s1      (fetch_s1),
		.vec_data_s1   (vec_data_s1)
	);

	mvp_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.fetch_s1     (fetch_s1),
		.vec_data_s1  (vec_data_s1),
		.row_count    (row_count_q),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.row_result   (row_result),
		.row_index    (row_index),
		.saturated    (saturated)
	);

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import mvp_pkg::*;

	// Run shape
	localparam int unsigned IDLE_PCT    = 16;    // idle chance per cycle, either side
	localparam int unsigned SETTLE_CYC  = 8;     // pipe is three deep; margin on top
	localparam int unsigned HOLD_CYC    = 300;   // one long result hold-off
	localparam int unsigned QUIET_LIMIT = 3000;  // cycles with nothing moving on any port
	localparam int unsigned RAND_ITEMS  = 250;
	localparam int unsigned CALM_FROM   = 700;   // window with no idling on either side
	localparam int unsigned CALM_TO     = 1500;
	localparam int unsigned BIG_PHASE   = 2;     // random phase after which a long row runs
	localparam int unsigned LONG_ROW    = 520;   // 512 full-scale products reach the bound

	localparam longint SUM_HI = 64'sd549755813887;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic        [ROW_W-1:0] row;
		logic                    sat;
	} row_sum_t;

	typedef enum logic [1:0] {STEP_ITEM, STEP_LEN, STEP_CNT} step_kind_t;

	typedef struct {
		step_kind_t              kind;
		logic                    req;
		logic signed [VAL_W-1:0] val;
		logic [APB_DW-1:0]       reg_val;
		bit                      known;   // expected row typed in below
		row_sum_t                want;
	} step_t;

	// DUT connections, inputs all driven to known values from time zero
	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     item_valid    = 1'b0;
	logic                     item_stall;
	logic                     req_type      = REQ_LOAD;
	logic signed [VAL_W-1:0]  element_value = '0;
	logic                     result_valid;
	logic                     result_stall  = 1'b0;
	logic signed [SUM_W-1:0]  row_result;
	logic        [ROW_W-1:0]  row_index;
	logic                     saturated;
	logic                     psel          = 1'b0;
	logic                     penable       = 1'b0;
	logic                     pwrite        = 1'b0;
	logic        [APB_AW-1:0] paddr         = '0;
	logic        [APB_DW-1:0] pwdata        = '0;
	logic        [APB_DW-1:0] prdata;
	logic                     pready;

	// Own copy of the block's state, at reset values
	logic [RLEN_W-1:0]       len_reg  = RLEN_W'(1024);
	logic [ROW_W-1:0]        rows_reg = ROW_W'(1024);
	logic signed [VAL_W-1:0] vec_copy [MAX_COLUMNS];
	int unsigned             load_at  = 0;
	int unsigned             col_at   = 0;
	int unsigned             row_at   = 0;
	longint                  acc      = 0;
	bit                      acc_clip = 1'b0;

	row_sum_t rows_due [$];   // rows predicted but not yet seen on the result port
	row_sum_t head;
	step_t    script [$];

	int unsigned mismatches = 0;
	int unsigned n_loads    = 0;
	int unsigned n_macs     = 0;
	int unsigned n_rows     = 0;
	int unsigned n_clamped  = 0;
	int unsigned n_writes   = 0;
	int unsigned cyc        = 0;
	int unsigned quiet      = 0;
	int unsigned hold_left  = 0;
	logic        squeeze_go = 1'b0;
	logic        squeezed   = 1'b0;

	matrix_vector_product i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.req_type      (req_type),
		.element_value (element_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.row_result    (row_result),
		.row_index     (row_index),
		.saturated     (saturated),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) cyc <= cyc + 1;

	function automatic bit calm();
		return (cyc >= CALM_FROM) && (cyc < CALM_TO);
	endfunction

	// Zero acts as one column, anything above the store depth as the full store
	function automatic int unsigned span(logic [RLEN_W-1:0] l);
		if (l == 0)
			return 1;
		if (l > MAX_COLUMNS)
			return MAX_COLUMNS;
		return 32'(l);
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_val();
		case ($urandom_range(15))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return -16'sd1;
			default: return VAL_W'($urandom());
		endcase
	endfunction

	function automatic step_t load_row(logic signed [VAL_W-1:0] v);
		step_t s;
		s.kind    = STEP_ITEM;
		s.req     = REQ_LOAD;
		s.val     = v;
		s.reg_val = '0;
		s.known   = 1'b0;
		s.want    = '0;
		return s;
	endfunction

	function automatic step_t mac_row(logic signed [VAL_W-1:0] v);
		step_t s;
		s     = load_row(v);
		s.req = REQ_MATRIX;
		return s;
	endfunction

	function automatic step_t mac_seen(logic signed [VAL_W-1:0] v, logic signed [SUM_W-1:0] sum,
			logic [ROW_W-1:0] row, logic sat);
		step_t s;
		s          = mac_row(v);
		s.known    = 1'b1;
		s.want.sum = sum;
		s.want.row = row;
		s.want.sat = sat;
		return s;
	endfunction

	function automatic step_t reg_row(step_kind_t k, logic [APB_DW-1:0] d);
		step_t s;
		s         = load_row('0);
		s.kind    = k;
		s.reg_val = d;
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("MISMATCH at %0d ns: %s", $time, what);
		mismatches++;
	endtask

	// One accepted item through the predictor. A finished row comes back in res.
	task automatic accumulate_element(input logic r, input logic signed [VAL_W-1:0] v,
			output bit done, output row_sum_t res);
		int unsigned len, pos, col;
		bit          last;
		longint      prod, s;
		len  = span(len_reg);
		done = 1'b0;
		res  = '0;
		if (r == REQ_LOAD) begin
			// load pointer wraps back to entry zero past the length
			pos           = (load_at < len) ? load_at : 0;
			vec_copy[pos] = v;
			load_at       = (pos + 1 >= len) ? 0 : pos + 1;
			n_loads++;
		end else begin
			// a column left beyond a lowered length reads entry zero and closes the row
			col  = (col_at < len) ? col_at : 0;
			last = (col_at + 1 >= len);
			prod = longint'(v) * longint'(vec_copy[col]);
			s    = acc + prod;
			if (s > SUM_HI) begin
				s        = SUM_HI;
				acc_clip = 1'b1;
			end else if (s < SUM_LO) begin
				s        = SUM_LO;
				acc_clip = 1'b1;
			end
			acc = s;
			n_macs++;
			if (!last) begin
				col_at = col + 1;
			end else begin
				done     = 1'b1;
				res.sum  = acc[SUM_W-1:0];
				res.row  = row_at[ROW_W-1:0];
				res.sat  = acc_clip;
				acc      = 0;
				acc_clip = 1'b0;
				col_at   = 0;
				// zero or a lowered row count wraps on the very next row
				row_at   = (row_at + 1 >= rows_reg) ? 0 : ((row_at + 1) & 32'hFFFF);
			end
		end
	endtask

	// Offer one item, with random idle cycles in front, and hold it until taken.
	task automatic offer_item(input logic r, input logic signed [VAL_W-1:0] v,
			input bit known = 1'b0, input row_sum_t want = '0);
		bit       done;
		row_sum_t res;
		while (!calm() && ($urandom_range(99) < IDLE_PCT)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid    <= 1'b1;
		req_type      <= r;
		element_value <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		accumulate_element(r, v, done, res);
		if (done)
			rows_due.push_back(known ? want : res);
	endtask

	// Wait for every predicted row, then let the pipe empty of row-less items.
	task automatic drain_block();
		item_valid <= 1'b0;
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Register write (setup + access), then read back, only with the block idle.
	task automatic write_reg(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] d);
		logic [APB_DW-1:0] held, rd;
		drain_block();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// written at that edge; now a read of the same register
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (a == ADDR_ROW_LENGTH) begin
			len_reg = d[RLEN_W-1:0];
			held    = APB_DW'(d[RLEN_W-1:0]);
		end else begin
			rows_reg = d[ROW_W-1:0];
			held     = APB_DW'(d[ROW_W-1:0]);
		end
		if (rd !== held)
			report_mismatch($sformatf("register at %0d reads %0h, wrote %0h", a, rd, held));
		n_writes++;
	endtask

	// Result side: random stall, one long hold-off on request, calm window.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (squeeze_go && !squeezed) begin
			squeezed     <= 1'b1;
			hold_left    <= HOLD_CYC;
			result_stall <= 1'b1;
		end else if (calm()) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Every accepted result against the oldest predicted row
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (rows_due.size() == 0) begin
				report_mismatch($sformatf("row item with nothing due: sum %0d row %0d sat %0b",
					row_result, row_index, saturated));
			end else begin
				head = rows_due.pop_front();
				if (row_result !== head.sum)
					report_mismatch($sformatf("row %0d sum %0d, want %0d",
						head.row, row_result, head.sum));
				if (row_index !== head.row)
					report_mismatch($sformatf("row index %0d, want %0d", row_index, head.row));
				if (saturated !== head.sat)
					report_mismatch($sformatf("row %0d clamp flag %0b, want %0b",
						head.row, saturated, head.sat));
				n_rows++;
				if (head.sat)
					n_clamped++;
			end
		end
	end

	// Watchdog: nothing moving on any port for too long ends the run
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("matrix_vector_product verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int unsigned phase, r, len_pick, cnt_pick, n, rand_done;

		// Directed steps. Rows with a typed result are the ones that read off directly:
		// single-column rows from reset and the product extremes.
		script.push_back(reg_row(STEP_LEN, 1));
		script.push_back(load_row(16'sd256));
		script.push_back(mac_seen(16'sd256, 40'sd65536, 16'd0, 1'b0));
		script.push_back(mac_seen(VAL_MIN, -40'sd8388608, 16'd1, 1'b0));
		script.push_back(load_row(VAL_MIN));
		script.push_back(mac_seen(VAL_MIN, 40'sd1073741824, 16'd2, 1'b0));
		script.push_back(mac_seen(VAL_MAX, -40'sd1073709056, 16'd3, 1'b0));
		script.push_back(load_row(VAL_MAX));
		script.push_back(mac_seen(VAL_MAX, 40'sd1073676289, 16'd4, 1'b0));
		// zero length behaves as one column
		script.push_back(reg_row(STEP_LEN, 0));
		script.push_back(load_row(16'sd5));
		script.push_back(mac_seen(16'sd3, 40'sd15, 16'd5, 1'b0));
		// zero row count: index wraps after each row
		script.push_back(reg_row(STEP_CNT, 0));
		script.push_back(mac_seen(16'sd1, 40'sd5, 16'd6, 1'b0));
		script.push_back(mac_seen(-16'sd1, -40'sd5, 16'd0, 1'b0));
		// two columns; third load wraps onto entry zero
		script.push_back(reg_row(STEP_LEN, 2));
		script.push_back(reg_row(STEP_CNT, 2));
		script.push_back(load_row(16'sd1));
		script.push_back(load_row(16'sd2));
		script.push_back(load_row(16'sd3));
		script.push_back(mac_row(16'sd10));
		// load in the middle of a row
		script.push_back(load_row(16'sd7));
		script.push_back(mac_row(16'sd1));
		// length cut while a row is half done
		script.push_back(reg_row(STEP_LEN, 4));
		script.push_back(load_row(16'sd11));
		script.push_back(load_row(16'sd12));
		script.push_back(load_row(16'sd13));
		script.push_back(load_row(16'sd14));
		script.push_back(mac_row(16'sd1));
		script.push_back(mac_row(16'sd1));
		script.push_back(reg_row(STEP_LEN, 2));
		script.push_back(mac_row(16'sd2));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			case (script[k].kind)
				STEP_LEN: write_reg(ADDR_ROW_LENGTH, script[k].reg_val);
				STEP_CNT: write_reg(ADDR_ROW_COUNT, script[k].reg_val);
				default:  offer_item(script[k].req, script[k].val, script[k].known, script[k].want);
			endcase
		end

		// Random phases: new settings, a full vector load, then a stream of matrix
		// items with the odd load mixed in.
		phase     = 0;
		rand_done = 0;
		while (rand_done < RAND_ITEMS) begin
			r = $urandom_range(99);
			if (phase == 0)
				len_pick = $urandom_range(1, 3);   // short rows so the hold-off backs up
			else if (r < 5)
				len_pick = 0;
			else if (r < 10)
				len_pick = 1;
			else if (r < 80)
				len_pick = $urandom_range(2, 8);
			else
				len_pick = $urandom_range(9, 48);
			r = $urandom_range(99);
			if (r < 10)
				cnt_pick = 0;
			else if (r < 20)
				cnt_pick = 1;
			else if (r < 60)
				cnt_pick = $urandom_range(2, 6);
			else if (r < 75)
				cnt_pick = 65535;
			else
				cnt_pick = $urandom_range(7, 65534);
			write_reg(ADDR_ROW_LENGTH, len_pick);
			write_reg(ADDR_ROW_COUNT, cnt_pick);

			// len loads from any start point cover every live entry
			repeat (span(RLEN_W'(len_pick))) offer_item(REQ_LOAD, rand_val());
			if (phase == 0)
				squeeze_go <= 1'b1;
			n = $urandom_range(30, 90);
			repeat (n) begin
				if ($urandom_range(99) < 10)
					offer_item(REQ_LOAD, rand_val());
				else
					offer_item(REQ_MATRIX, rand_val());
			end
			rand_done += n;

			if (phase == BIG_PHASE) begin
				// Close the open row at the old length, then one long row of extreme
				// products that clamps at the upper bound.
				while (col_at != 0)
					offer_item(REQ_MATRIX, rand_val());
				write_reg(ADDR_ROW_LENGTH, LONG_ROW);
				repeat (LONG_ROW) offer_item(REQ_LOAD, VAL_MIN);
				repeat (LONG_ROW) offer_item(REQ_MATRIX, VAL_MIN);
			end
			phase++;
		end

		drain_block();
		$display("covered %0d items (%0d vector loads, %0d matrix elements), %0d register writes",
			n_loads + n_macs, n_loads, n_macs, n_writes);
		$display("checked %0d row results over %0d random phases, %0d clamped at a bound",
			n_rows, phase, n_clamped);
		if (mismatches == 0)
			$display("matrix_vector_product verification clean");
		else
			$display("matrix_vector_product verification failed");
		$finish;
	end

endmodule
